FILE: hdl/tabular_q_learning_agent_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tabular Q-learning agent
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TABULAR_Q_LEARNING_AGENT_TOP_MACROS_SVH
`define TABULAR_Q_LEARNING_AGENT_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TQLA_ASSERT_SAME(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("tqla: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TQLA_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("tqla: next-cycle check failed");

`endif

FILE: hdl/tqla_pkg.sv
// ----------------------------------------------------------------------------
// Tabular Q-learning agent package
// Field widths, register codes, bin thresholds, sequencer states and decode.
// ----------------------------------------------------------------------------
package tqla_pkg;

   localparam int OBS_WIDTH       = 24;
   localparam int DRAW_WIDTH      = 16;
   localparam int REG_WIDTH       = 16;
   localparam int STATE_WIDTH     = 7;
   localparam int STATE_COUNT     = 81;
   localparam int ACTION_COUNT    = 2;
   localparam int TABLE_DEPTH     = STATE_COUNT * ACTION_COUNT;
   localparam int ADDR_WIDTH      = 8;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef logic signed [OBS_WIDTH-1:0] obs_type;
   typedef logic [REG_WIDTH-1:0]        reg_type;
   typedef logic [STATE_WIDTH-1:0]      state_idx_type;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEARN_RATE        = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DISCOUNT          = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPLORE_THRESHOLD = 2'd2;

   localparam reg_type LEARN_RATE_RESET        = 16'd6554;
   localparam reg_type DISCOUNT_RESET          = 16'd62259;
   localparam reg_type EXPLORE_THRESHOLD_RESET = 16'd7;

   // Bin edges in Q8.16; a bin index counts the edges strictly below the value.
   localparam obs_type POS_THR [4] = '{-24'sd98304, -24'sd32768, 24'sd32768, 24'sd98304};
   localparam obs_type VEL_THR [2] = '{-24'sd32768, 24'sd32768};
   localparam obs_type ANG_THR [7] = '{-24'sd13726, -24'sd6863, -24'sd1144, 24'sd0,
                                       24'sd1143, 24'sd6862, 24'sd13725};
   localparam obs_type RATE_THR [2] = '{-24'sd57191, 24'sd57190};

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_DECODE,
      SEQ_READ_LO,
      SEQ_READ_HI,
      SEQ_READ_CELL,
      SEQ_MUL_DISCOUNT,
      SEQ_TARGET,
      SEQ_DIFF,
      SEQ_MUL_RATE,
      SEQ_WRITE,
      SEQ_CHOOSE,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      logic          fail;
      state_idx_type index;
   } decode_type;

   // Bins the observation and folds angles above the middle by symmetry.
   function automatic decode_type decode_obs(input obs_type pos, input obs_type vel,
                                             input obs_type ang, input obs_type rate);
      logic [2:0] pos_cnt;
      logic [1:0] vel_cnt;
      logic [2:0] ang_cnt;
      logic [1:0] rate_cnt;
      logic [1:0] p;
      logic [1:0] v;
      logic [2:0] a;
      logic [1:0] r;
      decode_type res;
      pos_cnt  = '0;
      vel_cnt  = '0;
      ang_cnt  = '0;
      rate_cnt = '0;
      for (int i = 0; i < 4; i++) begin
         if (pos > POS_THR[i]) pos_cnt = pos_cnt + 3'd1;
      end
      for (int i = 0; i < 2; i++) begin
         if (vel > VEL_THR[i]) vel_cnt = vel_cnt + 2'd1;
         if (rate > RATE_THR[i]) rate_cnt = rate_cnt + 2'd1;
      end
      for (int i = 0; i < 7; i++) begin
         if (ang > ANG_THR[i]) ang_cnt = ang_cnt + 3'd1;
      end
      res.fail = (pos_cnt == 3'd0) || (pos_cnt == 3'd4) || (ang_cnt == 3'd0) ||
                 (ang_cnt == 3'd7);
      p = 2'(pos_cnt - 3'd1);
      v = vel_cnt;
      a = ang_cnt - 3'd1;
      r = rate_cnt;
      if (a > 3'd2) begin
         a = 3'd5 - a;
         p = 2'd2 - p;
         v = 2'd2 - v;
         r = 2'd2 - r;
      end
      if (res.fail) begin
         res.index = '0;
      end else begin
         res.index = 7'(p) + 7'(v) * 7'd3 + 7'(a) * 7'd9 + 7'(r) * 7'd27;
      end
      return res;
   endfunction

endpackage

FILE: hdl/tqla_if.sv
// ----------------------------------------------------------------------------
// Tabular Q-learning agent channels
// Valid/ready channels for observation requests and for results.
// ----------------------------------------------------------------------------
interface tqla_req_if;
   logic                       valid;
   logic                       ready;
   logic                       trial_start;
   tqla_pkg::obs_type          cart_position;
   tqla_pkg::obs_type          cart_velocity;
   tqla_pkg::obs_type          pole_angle;
   tqla_pkg::obs_type          pole_rate;
   logic [tqla_pkg::DRAW_WIDTH-1:0] random_draw;
   logic                       random_coin;

   modport source (output valid, trial_start, cart_position, cart_velocity, pole_angle,
                   pole_rate, random_draw, random_coin, input ready);
   modport sink (input valid, trial_start, cart_position, cart_velocity, pole_angle,
                 pole_rate, random_draw, random_coin, output ready);
endinterface

interface tqla_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic                          action_valid;
   logic                          failed;
   logic                          explored;
   tqla_pkg::state_idx_type       state_index;

   modport source (output valid, action, action_valid, failed, explored, state_index,
                   input ready);
   modport sink (input valid, action, action_valid, failed, explored, state_index,
                 output ready);
endinterface

FILE: hdl/tabular_q_learning_agent_top.sv
// ----------------------------------------------------------------------------
// Tabular Q-learning agent, epsilon-greedy, fixed point
// Bins a cart-pole observation, updates a Q-value table and picks an action.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Contents
//   req_chan  in         valid/ready        trial flag, four Q8.16 readings, draws
//   rsp_chan  out        valid/ready        action, flags, folded state index
//   csr_*     in         write enable only  learn rate, discount, explore threshold
//
// A trial start or a failing first step goes from decode straight to its
// result; other steps read the next state's row, a later step updates the
// previous cell, and a step that does not fail then chooses an action. The
// single read port of the Q-value table and the one shared multiplier set
// this order of steps. One request is in flight at a time. Reset is
// synchronous and clears the table's valid bits at once, so the block is
// ready in the cycle after reset. A finished result waits in an output
// register; the next request is taken while it waits, and the sequencer stalls
// only when a second result is ready before the first has been taken.
//
module tabular_q_learning_agent_top #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   tqla_req_if.sink                              req_chan,
   tqla_rsp_if.source                            rsp_chan,
   input  logic                                  csr_write_en,
   input  logic [tqla_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [tqla_pkg::REG_WIDTH-1:0]        csr_wdata
);

   // The product of a 16-bit fraction and a table value, and the value after
   // the fraction's 16 bits are dropped (floor, since the shift is arithmetic).
   localparam int PROD_WIDTH = VALUE_WIDTH + 17;
   localparam int WIDE_WIDTH = VALUE_WIDTH + 2;
   localparam logic signed [WIDE_WIDTH-1:0] FAIL_PENALTY =
      WIDE_WIDTH'(1) << (VALUE_WIDTH - 8);

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic signed [WIDE_WIDTH-1:0]  wide_type;

   // Clamps a widened sum back into the signed table range.
   function automatic value_type sat_value(input wide_type x);
      value_type res;
      if (x[WIDE_WIDTH-1:VALUE_WIDTH-1] == 3'b000 ||
          x[WIDE_WIDTH-1:VALUE_WIDTH-1] == 3'b111) begin
         res = x[VALUE_WIDTH-1:0];
      end else if (x[WIDE_WIDTH-1]) begin
         res = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      end else begin
         res = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      end
      return res;
   endfunction

   // Sequencer and agent state.
   tqla_pkg::seq_state_type state_ff, state_in;
   logic                    awaiting_first_ff;
   tqla_pkg::state_idx_type last_state_ff;
   logic                    last_action_ff;

   // Configuration registers.
   tqla_pkg::reg_type learn_rate_ff;
   tqla_pkg::reg_type discount_ff;
   tqla_pkg::reg_type explore_ff;

   // Captured request.
   logic                            trial_ff;
   tqla_pkg::obs_type               pos_ff;
   tqla_pkg::obs_type               vel_ff;
   tqla_pkg::obs_type               ang_ff;
   tqla_pkg::obs_type               rate_ff;
   logic [tqla_pkg::DRAW_WIDTH-1:0] draw_ff;
   logic                            coin_ff;

   // Decoded state and datapath registers.
   logic                    fail_ff;
   tqla_pkg::state_idx_type idx_ff;
   value_type               lo_val_ff;
   value_type               hi_val_ff;
   value_type               q_ff;
   value_type               target_ff;
   value_type               diff_ff;
   logic signed [PROD_WIDTH-1:0] prod_ff;

   // Action choice and result register.
   logic                    act_ff;
   logic                    act_valid_ff;
   logic                    explored_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_action_ff;
   logic                    rsp_action_valid_ff;
   logic                    rsp_failed_ff;
   logic                    rsp_explored_ff;
   tqla_pkg::state_idx_type rsp_index_ff;

   // Q-value table with one read and one write port.
   value_type                           table_mem [tqla_pkg::TABLE_DEPTH];
   logic [tqla_pkg::TABLE_DEPTH-1:0]    entry_valid_ff;
   value_type                           rd_data_ff;
   logic                                rd_valid_ff;

   // Combinational signals.
   tqla_pkg::decode_type              dec;
   tqla_pkg::state_idx_type           next_row;
   logic [tqla_pkg::ADDR_WIDTH-1:0]   cell_addr;
   logic [tqla_pkg::ADDR_WIDTH-1:0]   rd_addr;
   value_type                         rd_word;
   value_type                         max_val;
   tqla_pkg::reg_type                 mul_coef;
   value_type                         mul_operand;
   logic signed [16:0]                coef_signed;
   logic signed [PROD_WIDTH-1:0]      mul_result;
   logic signed [VALUE_WIDTH:0]       prod_shift;
   value_type                         target_in;
   value_type                         diff_in;
   value_type                         new_q;
   logic                              table_we;
   logic                              result_load;
   logic                              explore;
   logic                              greedy_act;

   assign dec       = tqla_pkg::decode_obs(pos_ff, vel_ff, ang_ff, rate_ff);
   // On a failing later step the value of the previous state stands in for
   // the next state's.
   assign next_row  = fail_ff ? last_state_ff : idx_ff;
   assign cell_addr = {last_state_ff, last_action_ff};
   assign rd_word   = rd_valid_ff ? rd_data_ff : '0;
   assign max_val   = (hi_val_ff > lo_val_ff) ? hi_val_ff : lo_val_ff;

   // Shared multiplier: discount times the best next value, then learn rate
   // times the temporal difference.
   assign coef_signed = $signed({1'b0, mul_coef});
   assign mul_result  = coef_signed * mul_operand;
   assign prod_shift  = prod_ff[PROD_WIDTH-1:16];

   assign target_in = sat_value(WIDE_WIDTH'(prod_shift) - (fail_ff ? FAIL_PENALTY : '0));
   assign diff_in   = sat_value(WIDE_WIDTH'(target_ff) - WIDE_WIDTH'(q_ff));
   assign new_q     = sat_value(WIDE_WIDTH'(q_ff) + WIDE_WIDTH'(prod_shift));

   // Ties between the two actions go to action 1.
   assign explore    = draw_ff <= explore_ff;
   assign greedy_act = !(lo_val_ff > hi_val_ff);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tqla_pkg::SEQ_IDLE: begin
            if (req_chan.valid) state_in = tqla_pkg::SEQ_DECODE;
         end
         tqla_pkg::SEQ_DECODE: begin
            if (trial_ff || (awaiting_first_ff && dec.fail)) begin
               state_in = tqla_pkg::SEQ_DONE;
            end else begin
               state_in = tqla_pkg::SEQ_READ_LO;
            end
         end
         tqla_pkg::SEQ_READ_LO:      state_in = tqla_pkg::SEQ_READ_HI;
         tqla_pkg::SEQ_READ_HI:      state_in = tqla_pkg::SEQ_READ_CELL;
         tqla_pkg::SEQ_READ_CELL: begin
            if (awaiting_first_ff) begin
               state_in = tqla_pkg::SEQ_CHOOSE;
            end else begin
               state_in = tqla_pkg::SEQ_MUL_DISCOUNT;
            end
         end
         tqla_pkg::SEQ_MUL_DISCOUNT: state_in = tqla_pkg::SEQ_TARGET;
         tqla_pkg::SEQ_TARGET:       state_in = tqla_pkg::SEQ_DIFF;
         tqla_pkg::SEQ_DIFF:         state_in = tqla_pkg::SEQ_MUL_RATE;
         tqla_pkg::SEQ_MUL_RATE:     state_in = tqla_pkg::SEQ_WRITE;
         tqla_pkg::SEQ_WRITE: begin
            if (fail_ff) begin
               state_in = tqla_pkg::SEQ_DONE;
            end else begin
               state_in = tqla_pkg::SEQ_CHOOSE;
            end
         end
         tqla_pkg::SEQ_CHOOSE:       state_in = tqla_pkg::SEQ_DONE;
         tqla_pkg::SEQ_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) state_in = tqla_pkg::SEQ_IDLE;
         end
         default:                    state_in = tqla_pkg::SEQ_IDLE;
      endcase
   end

   // Output and control decode of the sequencer state.
   always_comb begin
      req_chan.ready = 1'b0;
      rd_addr        = cell_addr;
      mul_coef       = learn_rate_ff;
      mul_operand    = diff_ff;
      table_we       = 1'b0;
      result_load    = 1'b0;
      case (state_ff)
         tqla_pkg::SEQ_IDLE:         req_chan.ready = 1'b1;
         tqla_pkg::SEQ_READ_LO:      rd_addr = {next_row, 1'b0};
         tqla_pkg::SEQ_READ_HI:      rd_addr = {next_row, 1'b1};
         tqla_pkg::SEQ_MUL_DISCOUNT: begin
            mul_coef    = discount_ff;
            mul_operand = max_val;
         end
         tqla_pkg::SEQ_WRITE:        table_we = 1'b1;
         tqla_pkg::SEQ_DONE:         result_load = !rsp_valid_ff || rsp_chan.ready;
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= tqla_pkg::SEQ_IDLE;
         awaiting_first_ff <= 1'b0;
         last_state_ff     <= '0;
         last_action_ff    <= 1'b0;
         learn_rate_ff     <= tqla_pkg::LEARN_RATE_RESET;
         discount_ff       <= tqla_pkg::DISCOUNT_RESET;
         explore_ff        <= tqla_pkg::EXPLORE_THRESHOLD_RESET;
         rsp_valid_ff      <= 1'b0;
         entry_valid_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            case (csr_index)
               tqla_pkg::CSR_LEARN_RATE:        learn_rate_ff <= csr_wdata;
               tqla_pkg::CSR_DISCOUNT:          discount_ff   <= csr_wdata;
               tqla_pkg::CSR_EXPLORE_THRESHOLD: explore_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (state_ff == tqla_pkg::SEQ_DECODE && trial_ff) awaiting_first_ff <= 1'b1;
         if (state_ff == tqla_pkg::SEQ_CHOOSE) begin
            awaiting_first_ff <= 1'b0;
            last_state_ff     <= idx_ff;
            last_action_ff    <= explore ? coin_ff : greedy_act;
         end
         if (table_we) entry_valid_ff[cell_addr] <= 1'b1;
         if (result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Table storage; entries never written read as zero through the valid bits.
   always_ff @(posedge clock) begin
      if (table_we) table_mem[cell_addr] <= new_q;
      rd_data_ff  <= table_mem[rd_addr];
      rd_valid_ff <= entry_valid_ff[rd_addr];
   end

   // Request capture and datapath registers.
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         trial_ff <= req_chan.trial_start;
         pos_ff   <= req_chan.cart_position;
         vel_ff   <= req_chan.cart_velocity;
         ang_ff   <= req_chan.pole_angle;
         rate_ff  <= req_chan.pole_rate;
         draw_ff  <= req_chan.random_draw;
         coin_ff  <= req_chan.random_coin;
      end
      case (state_ff)
         tqla_pkg::SEQ_DECODE: begin
            fail_ff      <= dec.fail;
            idx_ff       <= dec.index;
            act_ff       <= 1'b0;
            act_valid_ff <= 1'b0;
            explored_ff  <= 1'b0;
         end
         tqla_pkg::SEQ_READ_HI:      lo_val_ff <= rd_word;
         tqla_pkg::SEQ_READ_CELL:    hi_val_ff <= rd_word;
         tqla_pkg::SEQ_MUL_DISCOUNT: begin
            q_ff    <= rd_word;
            prod_ff <= mul_result;
         end
         tqla_pkg::SEQ_TARGET:       target_ff <= target_in;
         tqla_pkg::SEQ_DIFF:         diff_ff <= diff_in;
         tqla_pkg::SEQ_MUL_RATE:     prod_ff <= mul_result;
         tqla_pkg::SEQ_WRITE: begin
            // The greedy choice sees the value just written when the updated
            // entry lies in the row of the next state.
            if (last_state_ff == next_row) begin
               if (last_action_ff) begin
                  hi_val_ff <= new_q;
               end else begin
                  lo_val_ff <= new_q;
               end
            end
         end
         tqla_pkg::SEQ_CHOOSE: begin
            act_ff       <= explore ? coin_ff : greedy_act;
            act_valid_ff <= 1'b1;
            explored_ff  <= explore;
         end
         default: begin
         end
      endcase
      if (result_load) begin
         rsp_action_ff       <= act_ff && !trial_ff;
         rsp_action_valid_ff <= act_valid_ff && !trial_ff;
         rsp_explored_ff     <= explored_ff && !trial_ff;
         rsp_failed_ff       <= fail_ff && !trial_ff;
         rsp_index_ff        <= trial_ff ? '0 : idx_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.action       = rsp_action_ff;
   assign rsp_chan.action_valid = rsp_action_valid_ff;
   assign rsp_chan.failed       = rsp_failed_ff;
   assign rsp_chan.explored     = rsp_explored_ff;
   assign rsp_chan.state_index  = rsp_index_ff;

`include "tabular_q_learning_agent_top_macros.svh"

   `TQLA_ASSERT_NEXT(a_accept_decodes, clock, reset, req_chan.valid && req_chan.ready, state_ff == tqla_pkg::SEQ_DECODE)
   `TQLA_ASSERT_SAME(a_write_later_step, clock, reset, state_ff == tqla_pkg::SEQ_WRITE, !awaiting_first_ff && !trial_ff)
   `TQLA_ASSERT_SAME(a_action_not_failed, clock, reset, rsp_chan.valid && rsp_chan.action_valid, !rsp_chan.failed)
   `TQLA_ASSERT_SAME(a_explore_has_action, clock, reset, rsp_chan.valid && rsp_chan.explored, rsp_chan.action_valid)

endmodule

FILE: test/tabular_q_learning_agent_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tabular Q-learning agent testbench
// Sends cart-pole observations and checks every decision against a predictor
// that bins the readings, applies the Q-learning update and picks actions.
// ----------------------------------------------------------------------------
module tabular_q_learning_agent_top_tb;

   localparam int VALUE_WIDTH = 32;
   localparam longint VALUE_MAX = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
   localparam longint VALUE_MIN = -VALUE_MAX - 1;
   // The failure penalty of 1.0 in the Q8.(VALUE_WIDTH-8) format of the table.
   localparam longint ONE_VALUE = longint'(1) <<< (VALUE_WIDTH - 8);
   // The one index of the register port that maps to no register.
   localparam logic [tqla_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      bit                            trial_start;
      tqla_pkg::obs_type             position;
      tqla_pkg::obs_type             velocity;
      tqla_pkg::obs_type             angle;
      tqla_pkg::obs_type             rate;
      bit [tqla_pkg::DRAW_WIDTH-1:0] draw;
      bit                            coin;
   } observation_type;

   typedef struct {
      bit                      action;
      bit                      action_valid;
      bit                      failed;
      bit                      explored;
      tqla_pkg::state_idx_type state_index;
   } decision_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    csr_write_en;
   logic [tqla_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   tqla_pkg::reg_type csr_wdata;

   tqla_req_if req_chan ();
   tqla_rsp_if rsp_chan ();

   tabular_q_learning_agent_top #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The testbench's own copy of the agent: Q-value table, the state and action
   // of the previous step, the first-step flag and the three registers.
   longint  q_values [tqla_pkg::TABLE_DEPTH];
   int      prev_state;
   bit      prev_action;
   bit      awaiting_first_step;
   tqla_pkg::reg_type alpha_reg = tqla_pkg::LEARN_RATE_RESET;
   tqla_pkg::reg_type gamma_reg = tqla_pkg::DISCOUNT_RESET;
   tqla_pkg::reg_type epsilon_reg = tqla_pkg::EXPLORE_THRESHOLD_RESET;

   observation_type pending_obs [$];
   decision_type    expected_decisions [$];
   observation_type req_held;
   decision_type    want;

   // Requests queued and not yet answered; the phases wait on this reaching zero.
   int open_requests;
   int mismatches;
   int requests_sent;
   int responses_seen;
   int req_gap;
   int rsp_hold;
   bit req_quiet;
   bit rsp_quiet;

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   function automatic longint saturate(input longint x);
      if (x > VALUE_MAX) return VALUE_MAX;
      if (x < VALUE_MIN) return VALUE_MIN;
      return x;
   endfunction

   // Counts the bin edges strictly below each reading. Position and angle
   // outside their outer edges mean the pole or the cart has failed. Angles
   // above the middle are mirrored, which mirrors the other three bins too.
   function automatic bit bin_state(input observation_type o, output int idx);
      int p;
      int v;
      int a;
      int r;
      p = -1;
      v = 0;
      a = -1;
      r = 0;
      for (int i = 0; i < 4; i++) if (o.position > tqla_pkg::POS_THR[i]) p++;
      for (int i = 0; i < 2; i++) if (o.velocity > tqla_pkg::VEL_THR[i]) v++;
      for (int i = 0; i < 7; i++) if (o.angle > tqla_pkg::ANG_THR[i]) a++;
      for (int i = 0; i < 2; i++) if (o.rate > tqla_pkg::RATE_THR[i]) r++;
      if (p < 0 || p > 2 || a < 0 || a > 5) begin
         idx = 0;
         return 1'b1;
      end
      if (a > 2) begin
         a = 5 - a;
         p = 2 - p;
         v = 2 - v;
         r = 2 - r;
      end
      idx = p + 3 * v + 9 * a + 27 * r;
      return 1'b0;
   endfunction

   // Explores when the draw is at or below the threshold; otherwise action 1
   // wins ties.
   function automatic bit pick_action(input int s, input observation_type o,
                                      output bit chose_random);
      if (o.draw <= epsilon_reg) begin
         chose_random = 1'b1;
         return o.coin;
      end
      chose_random = 1'b0;
      return (q_values[s * tqla_pkg::ACTION_COUNT] >
              q_values[s * tqla_pkg::ACTION_COUNT + 1]) ? 1'b0 : 1'b1;
   endfunction

   function automatic decision_type learn_and_choose(input observation_type o);
      decision_type d;
      int        idx;
      int        next_state;
      int        slot;
      bit        failed;
      bit        chose_random;
      longint    best;
      longint    target;
      longint    current;
      longint    diff;
      d = '{default: 0};
      if (o.trial_start) begin
         awaiting_first_step = 1'b1;
         return d;
      end
      failed = bin_state(o, idx);
      d.failed = failed;
      d.state_index = 7'(idx);
      if (awaiting_first_step) begin
         // A first step that fails picks nothing and keeps waiting.
         if (!failed) begin
            d.action = pick_action(idx, o, chose_random);
            d.explored = chose_random;
            d.action_valid = 1'b1;
            prev_state = idx;
            prev_action = d.action;
            awaiting_first_step = 1'b0;
         end
         return d;
      end
      // On failure the update bootstraps from the previous state itself.
      slot = prev_state * tqla_pkg::ACTION_COUNT + prev_action;
      next_state = failed ? prev_state : idx;
      best = q_values[next_state * tqla_pkg::ACTION_COUNT];
      if (q_values[next_state * tqla_pkg::ACTION_COUNT + 1] > best)
         best = q_values[next_state * tqla_pkg::ACTION_COUNT + 1];
      target = (longint'(gamma_reg) * best) >>> 16;
      if (failed) target -= ONE_VALUE;
      target = saturate(target);
      current = q_values[slot];
      diff = saturate(target - current);
      q_values[slot] = saturate(current + ((longint'(alpha_reg) * diff) >>> 16));
      if (!failed) begin
         d.action = pick_action(idx, o, chose_random);
         d.explored = chose_random;
         d.action_valid = 1'b1;
         prev_action = d.action;
      end
      prev_state = next_state;
      return d;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------

   function automatic tqla_pkg::obs_type span(input int lo, input int hi);
      return tqla_pkg::obs_type'(lo + int'($urandom_range(hi - lo, 0)));
   endfunction

   // One below, at or one above a bin edge.
   function automatic tqla_pkg::obs_type nudge(input tqla_pkg::obs_type mark);
      return tqla_pkg::obs_type'(int'(mark) + int'($urandom_range(2, 0)) - 1);
   endfunction

   // Velocity and rate never cause failure, so any value is fair.
   function automatic tqla_pkg::obs_type loose_reading(input tqla_pkg::obs_type mark);
      case ($urandom_range(3, 0))
         0: begin
            return nudge(mark);
         end
         1: begin
            return tqla_pkg::obs_type'(24'($urandom()));
         end
         default: begin
            return span(-200000, 200000);
         end
      endcase
   endfunction

   // low_out and high_out are the nearest failing values on either side.
   function automatic tqla_pkg::obs_type out_of_bins(input int low_out, input int high_out);
      case ($urandom_range(3, 0))
         0: begin
            return tqla_pkg::obs_type'(low_out);
         end
         1: begin
            return tqla_pkg::obs_type'(high_out);
         end
         2: begin
            return span(-8388608, low_out);
         end
         default: begin
            return span(high_out, 8388607);
         end
      endcase
   endfunction

   // Draws cluster around the current threshold so both choices show up.
   function automatic bit [tqla_pkg::DRAW_WIDTH-1:0] pick_draw();
      case ($urandom_range(5, 0))
         0: begin
            return epsilon_reg;
         end
         1: begin
            return epsilon_reg + 16'd1;
         end
         2: begin
            return 16'($urandom_range(epsilon_reg, 0));
         end
         3: begin
            return ($urandom_range(1, 0) != 0) ? 16'hFFFF : 16'h0000;
         end
         default: begin
            return 16'($urandom());
         end
      endcase
   endfunction

   function automatic observation_type make_obs(input bit ts, input int pos, input int vel,
                                                input int ang, input int rate, input int draw,
                                                input bit coin);
      observation_type o;
      o.trial_start = ts;
      o.position = tqla_pkg::obs_type'(pos);
      o.velocity = tqla_pkg::obs_type'(vel);
      o.angle = tqla_pkg::obs_type'(ang);
      o.rate = tqla_pkg::obs_type'(rate);
      o.draw = 16'(draw);
      o.coin = coin;
      return o;
   endfunction

   function automatic observation_type noise_obs(input bit ts);
      observation_type o;
      o.trial_start = ts;
      o.position = tqla_pkg::obs_type'(24'($urandom()));
      o.velocity = tqla_pkg::obs_type'(24'($urandom()));
      o.angle = tqla_pkg::obs_type'(24'($urandom()));
      o.rate = tqla_pkg::obs_type'(24'($urandom()));
      o.draw = 16'($urandom());
      o.coin = 1'($urandom_range(1, 0));
      return o;
   endfunction

   function automatic observation_type in_bin_obs();
      observation_type o;
      o.trial_start = 1'b0;
      case ($urandom_range(3, 0))
         0: begin
            o.position = nudge(tqla_pkg::POS_THR[$urandom_range(2, 1)]);
         end
         1: begin
            o.position = ($urandom_range(1, 0) != 0) ? tqla_pkg::obs_type'(-98303) :
                                                       tqla_pkg::obs_type'(98304);
         end
         default: begin
            o.position = span(-98303, 98304);
         end
      endcase
      case ($urandom_range(3, 0))
         0: begin
            o.angle = nudge(tqla_pkg::ANG_THR[$urandom_range(5, 1)]);
         end
         1: begin
            o.angle = ($urandom_range(1, 0) != 0) ? tqla_pkg::obs_type'(-13725) :
                                                    tqla_pkg::obs_type'(13725);
         end
         default: begin
            o.angle = span(-13725, 13725);
         end
      endcase
      o.velocity = loose_reading(tqla_pkg::VEL_THR[$urandom_range(1, 0)]);
      o.rate = loose_reading(tqla_pkg::RATE_THR[$urandom_range(1, 0)]);
      o.draw = pick_draw();
      o.coin = 1'($urandom_range(1, 0));
      return o;
   endfunction

   function automatic observation_type failing_obs();
      observation_type o;
      int              which;
      o = in_bin_obs();
      which = $urandom_range(2, 0);
      if (which != 1) o.position = out_of_bins(-98304, 98305);
      if (which != 0) o.angle = out_of_bins(-13726, 13726);
      return o;
   endfunction

   task automatic enqueue(input observation_type o);
      pending_obs.push_back(o);
      open_requests++;
   endtask

   // Mostly whole trials: a start, sometimes a failing first step, a run of
   // in-bin steps and a few failures at the end. One in ten is pure noise.
   task automatic queue_episodes(input int item_goal);
      int queued;
      queued = 0;
      while (queued < item_goal) begin
         if ($urandom_range(9, 0) == 0) begin
            enqueue(noise_obs(1'($urandom_range(1, 0))));
            queued++;
         end else begin
            enqueue(noise_obs(1'b1));
            queued++;
            if ($urandom_range(7, 0) == 0) begin
               enqueue(failing_obs());
               queued++;
            end
            repeat ($urandom_range(30, 1)) begin
               enqueue(in_bin_obs());
               queued++;
            end
            repeat ($urandom_range(3, 0)) begin
               enqueue(failing_obs());
               queued++;
            end
         end
      end
   endtask

   // Registers are only written while nothing is in flight. The spare index
   // is written too; the block must ignore it.
   task automatic apply_settings(input tqla_pkg::reg_type alpha,
                                 input tqla_pkg::reg_type gamma,
                                 input tqla_pkg::reg_type epsilon);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= tqla_pkg::CSR_LEARN_RATE;
      csr_wdata <= alpha;
      alpha_reg = alpha;
      @(posedge clock);
      csr_index <= tqla_pkg::CSR_DISCOUNT;
      csr_wdata <= gamma;
      gamma_reg = gamma;
      @(posedge clock);
      csr_index <= tqla_pkg::CSR_EXPLORE_THRESHOLD;
      csr_wdata <= epsilon;
      epsilon_reg = epsilon;
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= 16'($urandom());
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic drain();
      wait (open_requests == 0);
   endtask

   // ---------------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------------

   task automatic present_next();
      req_held = pending_obs.pop_front();
      req_chan.valid         <= 1'b1;
      req_chan.trial_start   <= req_held.trial_start;
      req_chan.cart_position <= req_held.position;
      req_chan.cart_velocity <= req_held.velocity;
      req_chan.pole_angle    <= req_held.angle;
      req_chan.pole_rate     <= req_held.rate;
      req_chan.random_draw   <= req_held.draw;
      req_chan.random_coin   <= req_held.coin;
   endtask

   // Each accepted request is predicted at once, then a gap is drawn before
   // the next one. Every fifty requests the driver may switch to a stretch
   // with no gaps at all. With no gap, valid simply stays high.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_gap = 0;
      end else if (req_chan.valid && req_chan.ready) begin
         expected_decisions.push_back(learn_and_choose(req_held));
         requests_sent++;
         if (requests_sent % 50 == 0) req_quiet = ($urandom_range(2, 0) == 0);
         req_gap = req_quiet ? 0 : $urandom_range(15, 0);
         if (req_gap == 0 && pending_obs.size() != 0) present_next();
         else req_chan.valid <= 1'b0;
      end else if (!req_chan.valid) begin
         if (req_gap != 0) req_gap--;
         else if (pending_obs.size() != 0) present_next();
      end
   end

   // ---------------------------------------------------------------------------
   // Response monitor
   // ---------------------------------------------------------------------------

   function automatic void check_field(input string field, input logic [6:0] expected_val,
                                       input logic [6:0] actual_val);
      if (actual_val !== expected_val) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("response %0d, %s: expected %0d, got %0d", responses_seen, field,
                     expected_val, actual_val);
      end
   endfunction

   // Ready is held low for a drawn number of cycles after each response, so
   // the block sometimes has to keep a finished result waiting.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_chan.ready && rsp_chan.valid) begin
         responses_seen++;
         if (expected_decisions.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("response %0d arrived with no request outstanding", responses_seen);
         end else begin
            want = expected_decisions.pop_front();
            check_field("action", 7'(want.action), 7'(rsp_chan.action));
            check_field("action_valid", 7'(want.action_valid), 7'(rsp_chan.action_valid));
            check_field("failed", 7'(want.failed), 7'(rsp_chan.failed));
            check_field("explored", 7'(want.explored), 7'(rsp_chan.explored));
            check_field("state_index", want.state_index, rsp_chan.state_index);
            open_requests--;
         end
         if (responses_seen % 50 == 0) rsp_quiet = ($urandom_range(2, 0) == 0);
         rsp_hold = rsp_quiet ? 0 : $urandom_range(15, 0);
         if (rsp_hold != 0) rsp_chan.ready <= 1'b0;
      end else if (!rsp_chan.ready) begin
         if (rsp_hold <= 1) begin
            rsp_chan.ready <= 1'b1;
            rsp_hold = 0;
         end else begin
            rsp_hold--;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------

   initial begin
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.trial_start = 1'b0;
      req_chan.cart_position = '0;
      req_chan.cart_velocity = '0;
      req_chan.pole_angle = '0;
      req_chan.pole_rate = '0;
      req_chan.random_draw = '0;
      req_chan.random_coin = 1'b0;
      rsp_chan.ready = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset settings written explicitly. The first
      // step comes before any trial start, so it takes the update path from
      // state 0 and action 0.
      apply_settings(tqla_pkg::LEARN_RATE_RESET, tqla_pkg::DISCOUNT_RESET,
                     tqla_pkg::EXPLORE_THRESHOLD_RESET);
      enqueue(make_obs(0, 0, 0, 500, 0, 65535, 0));
      enqueue(make_obs(1, -8388608, 8388607, -8388608, 8388607, 65535, 1));
      // Failing first steps: far out, at the angle's maximum, at the exact edge.
      enqueue(make_obs(0, -8388608, 0, 0, 0, 0, 1));
      enqueue(make_obs(0, 0, 0, 8388607, 0, 0, 1));
      enqueue(make_obs(0, -98304, 0, 0, 0, 0, 0));
      // First step that explores at a draw equal to the threshold.
      enqueue(make_obs(0, -98303, -32768, -13725, -57191, 7, 1));
      // Steps that walk every bin edge of every reading.
      enqueue(make_obs(0, 98304, -32767, -6863, -57190, 8, 0));
      enqueue(make_obs(0, 32768, 32768, -6862, 57190, 0, 0));
      enqueue(make_obs(0, 32769, 32769, -1144, 57191, 65535, 1));
      enqueue(make_obs(0, -32768, 8388607, -1143, -8388608, 6, 1));
      enqueue(make_obs(0, -32767, -8388608, 0, 0, 7, 0));
      enqueue(make_obs(0, 0, 0, 1, 0, 8, 1));
      enqueue(make_obs(0, 0, 0, 1143, 0, 100, 0));
      enqueue(make_obs(0, 0, 0, 1144, 0, 100, 0));
      enqueue(make_obs(0, 0, 0, 6862, 0, 100, 0));
      enqueue(make_obs(0, 0, 0, 6863, 0, 100, 0));
      enqueue(make_obs(0, 0, 0, 13725, 0, 100, 0));
      // Failures on later steps, back to back, then a recovery.
      enqueue(make_obs(0, 0, 0, 13726, 0, 0, 1));
      enqueue(make_obs(0, 98305, 0, 0, 0, 0, 1));
      enqueue(make_obs(0, 0, 0, -13726, 0, 0, 0));
      enqueue(make_obs(0, 50000, 1000, -3000, 2000, 3, 1));
      // Two trial starts in a row, then a greedy first step.
      enqueue(make_obs(1, 0, 0, 0, 0, 0, 0));
      enqueue(make_obs(1, 98305, -1, 13726, -1, 65535, 0));
      enqueue(make_obs(0, 0, 0, -3000, 0, 65535, 0));
      enqueue(make_obs(0, -1, -1, -1, -1, 9, 1));
      drain();

      // Both fractions at their maximum and exploration always on. Trials that
      // fail right after the first step, with the action alternating, drive
      // both values of one state far below zero.
      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
      for (int k = 0; k < 200; k++) begin
         enqueue(noise_obs(1'b1));
         enqueue(make_obs(0, 0, 0, -3000, 0, $urandom_range(65535, 0), k[0]));
         enqueue(failing_obs());
      end
      // From that low-valued state into another one: the difference is large and positive.
      enqueue(noise_obs(1'b1));
      enqueue(make_obs(0, 0, 0, -3000, 0, 0, 1));
      enqueue(make_obs(0, 50000, 50000, -10000, 0, 0, 0));
      queue_episodes(60);
      drain();

      // Both fractions zero and exploration only at a draw of zero.
      apply_settings(16'h0000, 16'h0000, 16'h0000);
      queue_episodes(180);
      drain();

      apply_settings(16'hFFFF, 16'h0000, 16'($urandom_range(2000, 0)));
      queue_episodes(150);
      drain();

      apply_settings(16'd32768, 16'hFFFF, 16'd40000);
      queue_episodes(150);
      drain();

      repeat (2) begin
         apply_settings(16'($urandom()), 16'($urandom()), 16'($urandom_range(20000, 0)));
         queue_episodes(110);
         drain();
      end

      apply_settings(tqla_pkg::LEARN_RATE_RESET, tqla_pkg::DISCOUNT_RESET,
                     tqla_pkg::EXPLORE_THRESHOLD_RESET);
      queue_episodes(120);
      drain();

      // Wait longer than the longest step, to catch a stray response.
      repeat (24) @(posedge clock);
      if (mismatches == 0 && expected_decisions.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Ends the run if it hangs, well beyond the time the slowest correct run takes.
   initial begin
      #4ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/tqla_pkg.sv
hdl/tqla_if.sv
hdl/tabular_q_learning_agent_top.sv
test/tabular_q_learning_agent_top_tb.sv
